### sv/dsd_pkg.sv
// Package for the dielectric scatter direction block: beat types, lane record and stage plan.
package dsd_pkg;

  localparam int unsigned ONE_Q14 = 16384;
  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;
  localparam logic [15:0] IOR_RESET = 16'd24576;

  // Stage plan of the pipeline. Stage numbers count registers after the input beat.
  localparam int NSTAGE      = 54;
  localparam int ST_PREP     = 1;
  localparam int ST_INIT     = 2;
  localparam int ST_DIV      = 3;
  localparam int DIV_STEPS   = 29;
  localparam int KDIV_STEPS  = 14;
  localparam int XDIV_STEPS  = 16;
  localparam int ST_PROD     = 3;
  localparam int ST_T2L      = 4;
  localparam int ST_PXZ      = 5;
  localparam int ST_R0       = ST_DIV + KDIV_STEPS;
  localparam int ST_SEL      = ST_DIV + DIV_STEPS;
  localparam int ST_SQRT     = ST_SEL + 1;
  localparam int SQRT_STEPS  = 15;
  localparam int ST_COSF     = ST_SQRT + SQRT_STEPS;
  localparam int ST_POW      = ST_COSF + 1;
  localparam int POW_STEPS   = 4;
  localparam int ST_REFL     = ST_POW + POW_STEPS;
  localparam int ST_OUT      = ST_REFL + 1;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        random_fraction;
  } ray_beat_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               was_reflected;
    logic [14:0]        reflectance;
  } scatter_beat_t;

  // Working record carried by every pipeline stage.
  typedef struct packed {
    logic               ent;
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
    logic [15:0]        rnd;
    logic [15:0]        q;
    logic [14:0]        c;
    logic [15:0]        mx;
    logic [15:0]        mz;
    logic [28:0]        cc;
    logic [31:0]        qq;
    logic [28:0]        s2;
    logic [31:0]        rem1;
    logic [28:0]        quo1;
    logic [16:0]        remk;
    logic [16:0]        dk;
    logic [13:0]        quok;
    logic [15:0]        remx;
    logic [15:0]        remz;
    logic [15:0]        quox;
    logic [15:0]        quoz;
    logic [44:0]        pa;
    logic [44:0]        pb;
    logic [32:0]        t2l;
    logic [17:0]        px;
    logic [17:0]        pz;
    logic [13:0]        r0;
    logic               tir;
    logic [29:0]        sv;
    logic [16:0]        srem;
    logic [14:0]        root;
    logic [14:0]        rx;
    logic [14:0]        rz;
    logic [14:0]        xb;
    logic [14:0]        x5;
    logic [14:0]        refl;
    scatter_beat_t      res;
  } lane_t;

  function automatic logic signed [15:0] sat_unit(input logic signed [16:0] v);
    if (v > 17'sd16384) begin
      return 16'sd16384;
    end else if (v < -17'sd16384) begin
      return -16'sd16384;
    end
    return v[15:0];
  endfunction

  function automatic logic [14:0] sat_mag(input logic [17:0] v);
    if (v > 18'(ONE_Q14)) begin
      return 15'(ONE_Q14);
    end
    return v[14:0];
  endfunction

endpackage

### sv/dielectric_scatter_direction.sv
// Dielectric scatter direction: Schlick Fresnel choice of mirror or Snell refraction.
// Throughput: one beat per cycle; the pipeline holds as a whole only while the
// output beat is stalled, and then the input is stalled too.
// Reset (synchronous, rst high) empties the pipeline and sets the index to 1.5.
// The index is sampled with each ray beat, so it travels with the ray.
module dielectric_scatter_direction (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   refraction_index_we,
  input  logic [15:0]            refraction_index,
  input  logic                   ray_valid,
  output logic                   ray_stall,
  input  dsd_pkg::ray_beat_t     ray,
  output logic                   scatter_valid,
  input  logic                   scatter_stall,
  output dsd_pkg::scatter_beat_t scatter
);
  import dsd_pkg::*;

  logic [15:0]      ior_reg;
  logic [NSTAGE:1]  vld;
  lane_t            pipe [1:NSTAGE];
  lane_t            nxt  [1:NSTAGE];
  logic             adv;

  // The whole pipeline moves unless the finished beat at the end is held up.
  assign adv           = !(vld[NSTAGE] && scatter_stall);
  assign ray_stall     = !adv;
  assign scatter_valid = vld[NSTAGE];
  assign scatter       = pipe[NSTAGE].res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ior_reg <= IOR_RESET;
    end else if (refraction_index_we) begin
      ior_reg <= refraction_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-1:1], ray_valid};
    end
  end

  genvar s;
  generate
    for (s = 1; s <= NSTAGE; s++) begin : g_stage
      always_ff @(posedge clk) begin
        if (adv) begin
          pipe[s] <= nxt[s];
        end
      end

      if (s == ST_PREP) begin : g_first
        // Pick the side of the surface, clamp the cosine and square both ratios' basis.
        always_comb begin
          logic [16:0] aby;
          logic [15:0] qv;
          nxt[s] = '0;
          qv = (ior_reg < 16'(ONE_Q14)) ? 16'(ONE_Q14) : ior_reg;
          aby = ray.dir_y[15] ? 17'(17'sd0 - 17'(ray.dir_y)) : 17'(ray.dir_y);
          nxt[s].ent = ray.dir_y > 16'sd0;
          nxt[s].wx  = ray.dir_x;
          nxt[s].wy  = ray.dir_y;
          nxt[s].wz  = ray.dir_z;
          nxt[s].rnd = ray.random_fraction;
          nxt[s].q   = qv;
          nxt[s].c   = (aby > 17'(ONE_Q14)) ? 15'(ONE_Q14) : aby[14:0];
          nxt[s].mx  = ray.dir_x[15] ? 16'(16'sd0 - ray.dir_x) : ray.dir_x;
          nxt[s].mz  = ray.dir_z[15] ? 16'(16'sd0 - ray.dir_z) : ray.dir_z;
          nxt[s].cc  = 29'(30'(nxt[s].c) * 30'(nxt[s].c));
          nxt[s].qq  = 32'(qv) * 32'(qv);
        end
      end else begin : g_rest
        always_comb begin
          logic [32:0] sh1;
          logic [17:0] shk;
          logic [16:0] shx;
          logic [16:0] shz;
          logic [18:0] shs;
          logic [16:0] trial;
          logic [60:0] sum;
          logic [32:0] t2;
          logic [29:0] pw;
          logic [14:0] cosf;
          logic [15:0] rr;
          logic signed [16:0] yv;
          nxt[s] = pipe[s-1];
          sh1 = '0; shk = '0; shx = '0; shz = '0; shs = '0; trial = '0;
          sum = '0; t2 = '0; pw = '0; cosf = '0; rr = '0; yv = '0;

          if (s == ST_INIT) begin
            nxt[s].s2   = ONE_Q28 - pipe[s-1].cc;
            nxt[s].rem1 = 32'(nxt[s].s2[28:1]);
            nxt[s].quo1 = '0;
            nxt[s].remk = 17'(pipe[s-1].q) - 17'(ONE_Q14);
            nxt[s].dk   = 17'(pipe[s-1].q) + 17'(ONE_Q14);
            nxt[s].quok = '0;
            nxt[s].remx = pipe[s-1].mx >> 2;
            nxt[s].remz = pipe[s-1].mz >> 2;
            nxt[s].quox = '0;
            nxt[s].quoz = '0;
          end

          // Restoring division, one quotient bit per stage for each divider.
          if (s >= ST_DIV && s < ST_DIV + DIV_STEPS) begin
            sh1 = {pipe[s-1].rem1, (s == ST_DIV) ? pipe[s-1].s2[0] : 1'b0};
            if (sh1 >= {1'b0, pipe[s-1].qq}) begin
              nxt[s].rem1 = 32'(sh1 - {1'b0, pipe[s-1].qq});
              nxt[s].quo1 = {pipe[s-1].quo1[27:0], 1'b1};
            end else begin
              nxt[s].rem1 = sh1[31:0];
              nxt[s].quo1 = {pipe[s-1].quo1[27:0], 1'b0};
            end
          end

          if (s >= ST_DIV && s < ST_DIV + KDIV_STEPS) begin
            shk = {pipe[s-1].remk, 1'b0};
            if (shk >= {1'b0, pipe[s-1].dk}) begin
              nxt[s].remk = 17'(shk - {1'b0, pipe[s-1].dk});
              nxt[s].quok = {pipe[s-1].quok[12:0], 1'b1};
            end else begin
              nxt[s].remk = shk[16:0];
              nxt[s].quok = {pipe[s-1].quok[12:0], 1'b0};
            end
          end

          if (s >= ST_DIV && s < ST_DIV + XDIV_STEPS) begin
            shx = {pipe[s-1].remx, (s == ST_DIV) ? pipe[s-1].mx[1] :
                   (s == ST_DIV + 1) ? pipe[s-1].mx[0] : 1'b0};
            shz = {pipe[s-1].remz, (s == ST_DIV) ? pipe[s-1].mz[1] :
                   (s == ST_DIV + 1) ? pipe[s-1].mz[0] : 1'b0};
            if (shx >= {1'b0, pipe[s-1].q}) begin
              nxt[s].remx = 16'(shx - {1'b0, pipe[s-1].q});
              nxt[s].quox = {pipe[s-1].quox[14:0], 1'b1};
            end else begin
              nxt[s].remx = shx[15:0];
              nxt[s].quox = {pipe[s-1].quox[14:0], 1'b0};
            end
            if (shz >= {1'b0, pipe[s-1].q}) begin
              nxt[s].remz = 16'(shz - {1'b0, pipe[s-1].q});
              nxt[s].quoz = {pipe[s-1].quoz[14:0], 1'b1};
            end else begin
              nxt[s].remz = shz[15:0];
              nxt[s].quoz = {pipe[s-1].quoz[14:0], 1'b0};
            end
          end

          // Leaving side: the squared ratio times the squared sine, in two halves.
          if (s == ST_PROD) begin
            nxt[s].pa = 45'(pipe[s-1].qq[31:16]) * 45'(pipe[s-1].s2);
            nxt[s].pb = 45'(pipe[s-1].qq[15:0]) * 45'(pipe[s-1].s2);
          end
          if (s == ST_T2L) begin
            sum = {pipe[s-1].pa, 16'b0} + 61'(pipe[s-1].pb);
            nxt[s].t2l = sum[60:28];
          end
          if (s == ST_PXZ) begin
            nxt[s].px = 18'((32'(pipe[s-1].mx) * 32'(pipe[s-1].q)) >> 14);
            nxt[s].pz = 18'((32'(pipe[s-1].mz) * 32'(pipe[s-1].q)) >> 14);
          end
          if (s == ST_R0) begin
            nxt[s].r0 = 14'((28'(pipe[s-1].quok) * 28'(pipe[s-1].quok)) >> 14);
          end

          if (s == ST_SEL) begin
            t2 = pipe[s-1].ent ? 33'(pipe[s-1].quo1) : pipe[s-1].t2l;
            nxt[s].tir  = t2 > 33'(ONE_Q28);
            nxt[s].sv   = nxt[s].tir ? 30'd0 : 30'(33'(ONE_Q28) - t2);
            nxt[s].srem = '0;
            nxt[s].root = '0;
            nxt[s].rx   = pipe[s-1].ent ? sat_mag(18'(pipe[s-1].quox)) : sat_mag(pipe[s-1].px);
            nxt[s].rz   = pipe[s-1].ent ? sat_mag(18'(pipe[s-1].quoz)) : sat_mag(pipe[s-1].pz);
          end

          // Square root, one result bit per stage from the top pair of radicand bits.
          if (s >= ST_SQRT && s < ST_SQRT + SQRT_STEPS) begin
            shs   = {pipe[s-1].srem, pipe[s-1].sv[29:28]};
            trial = {pipe[s-1].root, 2'b01};
            nxt[s].sv = {pipe[s-1].sv[27:0], 2'b00};
            if (shs >= 19'(trial)) begin
              nxt[s].srem = 17'(shs - 19'(trial));
              nxt[s].root = {pipe[s-1].root[13:0], 1'b1};
            end else begin
              nxt[s].srem = shs[16:0];
              nxt[s].root = {pipe[s-1].root[13:0], 1'b0};
            end
          end

          if (s == ST_COSF) begin
            cosf = (!pipe[s-1].ent && pipe[s-1].q > 16'(ONE_Q14)) ?
                   pipe[s-1].root : pipe[s-1].c;
            nxt[s].xb = 15'(ONE_Q14) - cosf;
            nxt[s].x5 = nxt[s].xb;
          end

          if (s >= ST_POW && s < ST_POW + POW_STEPS) begin
            pw = 30'(pipe[s-1].x5) * 30'(pipe[s-1].xb);
            nxt[s].x5 = pw[28:14];
          end

          if (s == ST_REFL) begin
            pw = 30'(15'(ONE_Q14) - 15'(pipe[s-1].r0)) * 30'(pipe[s-1].x5);
            nxt[s].refl = pipe[s-1].tir ? 15'(ONE_Q14) :
                          15'(pipe[s-1].r0) + pw[28:14];
          end

          if (s == ST_OUT) begin
            nxt[s].res.reflectance   = pipe[s-1].refl;
            nxt[s].res.was_reflected = {1'b0, pipe[s-1].rnd} < {pipe[s-1].refl, 2'b00};
            if (nxt[s].res.was_reflected) begin
              nxt[s].res.out_x = sat_unit(17'sd0 - 17'(pipe[s-1].wx));
              nxt[s].res.out_y = sat_unit(17'(pipe[s-1].wy));
              nxt[s].res.out_z = sat_unit(17'sd0 - 17'(pipe[s-1].wz));
            end else begin
              rr = 16'(pipe[s-1].rx);
              nxt[s].res.out_x = pipe[s-1].wx[15] ? rr : 16'(16'd0 - rr);
              rr = 16'(pipe[s-1].rz);
              nxt[s].res.out_z = pipe[s-1].wz[15] ? rr : 16'(16'd0 - rr);
              yv = 17'(pipe[s-1].root);
              nxt[s].res.out_y = pipe[s-1].ent ? 16'(17'sd0 - yv) : yv[15:0];
            end
          end
        end
      end
    end
  endgenerate

endmodule

### test/tb_dielectric_scatter_direction.sv
// Self-checking testbench for the dielectric scatter direction block.
`timescale 1ns / 1ps

module tb_dielectric_scatter_direction;
  import dsd_pkg::*;

  localparam int LATENCY = 54;
  localparam int ONE = 16384;
  localparam int HOLD_OFF_LEN = 3 * LATENCY;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic refraction_index_we = 1'b0;
  logic [15:0] refraction_index = 16'd0;
  logic ray_valid = 1'b0;
  logic ray_stall;
  ray_beat_t ray = '0;
  logic scatter_valid;
  logic scatter_stall = 1'b0;
  scatter_beat_t scatter;

  dielectric_scatter_direction u_dut (
    .clk(clk), .rst(rst),
    .refraction_index_we(refraction_index_we), .refraction_index(refraction_index),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .scatter_valid(scatter_valid), .scatter_stall(scatter_stall), .scatter(scatter)
  );

  // Pending rays for the driver, and the scatter beats that the accepted rays should yield.
  ray_beat_t pending_rays[$];
  scatter_beat_t expected_scatter[$];
  logic [15:0] index_model = IOR_RESET;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  bit hold_off_go = 1'b0;
  bit hold_off_done = 1'b0;
  int unsigned hold_off_count = 0;
  bit failed = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Integer square root, truncated.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Refracted tangential component: -(w/n) when entering, -(n*w) when leaving, truncated towards zero, saturated.
  function automatic logic signed [15:0] bend_component(input int w, input logic [63:0] q,
                                                        input bit entering);
    logic [63:0] mag;
    logic [63:0] p;
    mag = (w < 0) ? -w : w;
    p = entering ? (mag << 14) / q : (mag * q) >> 14;
    if (p > ONE) p = ONE;
    return (w < 0) ? 16'(int'(p)) : 16'(-int'(p));
  endfunction

  function automatic logic signed [15:0] clamp_unit(input int v);
    if (v > ONE) return 16'sd16384;
    if (v < -ONE) return -16'sd16384;
    return 16'(v);
  endfunction

  // Works out the scatter beat for one ray under the current index.
  function automatic scatter_beat_t scatter_of(input ray_beat_t r, input logic [15:0] ior);
    scatter_beat_t res;
    int wx;
    int wy;
    int wz;
    logic [63:0] q;
    logic [63:0] c;
    logic [63:0] s2;
    logic [63:0] qq;
    logic [63:0] t2;
    logic [63:0] cos_t;
    logic [63:0] cos_f;
    logic [63:0] x;
    logic [63:0] x5;
    logic [63:0] k;
    logic [63:0] r0;
    logic [63:0] refl;
    bit entering;
    bit tir;
    wx = int'(r.dir_x);
    wy = int'(r.dir_y);
    wz = int'(r.dir_z);
    q = (ior < ONE) ? ONE : ior;
    entering = wy > 0;
    c = entering ? wy : -wy;
    if (c > ONE) c = ONE;
    s2 = (64'd1 << 28) - c * c;
    qq = q * q;
    t2 = entering ? (s2 << 28) / qq : (qq * s2) >> 28;
    tir = t2 > (64'd1 << 28);
    cos_t = tir ? 0 : floor_sqrt((64'd1 << 28) - t2);
    k = ((q - ONE) << 14) / (q + ONE);
    r0 = (k * k) >> 14;
    if (tir) begin
      refl = ONE;
    end else begin
      cos_f = (!entering && q > ONE) ? cos_t : c;
      x = ONE - cos_f;
      x5 = x;
      for (int i = 0; i < 4; i++) x5 = (x5 * x) >> 14;
      refl = r0 + (((ONE - r0) * x5) >> 14);
    end
    res.reflectance = refl[14:0];
    res.was_reflected = r.random_fraction < (refl << 2);
    if (res.was_reflected) begin
      res.out_x = clamp_unit(-wx);
      res.out_y = clamp_unit(wy);
      res.out_z = clamp_unit(-wz);
    end else begin
      res.out_x = bend_component(wx, q, entering);
      res.out_z = bend_component(wz, q, entering);
      res.out_y = entering ? 16'(-int'(cos_t)) : 16'(int'(cos_t));
    end
    return res;
  endfunction

  // Driver: offers queued rays, holding the payload steady while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (ray_valid && !ray_stall) begin
        expected_scatter.push_back(scatter_of(ray, index_model));
        void'(pending_rays.pop_front());
      end
      if (!ray_valid || !ray_stall) begin
        if (pending_rays.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          ray_valid <= 1'b1;
          ray <= pending_rays[0];
        end else begin
          ray_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off: once requested, counts a long stretch of cycles and then ends.
  always @(posedge clk) begin
    if (hold_off_go && !hold_off_done) begin
      if (hold_off_count == HOLD_OFF_LEN - 1) begin
        hold_off_done <= 1'b1;
      end
      hold_off_count <= hold_off_count + 1;
    end
  end

  // Monitor: checks each accepted scatter beat against the oldest expectation and
  // decides the receiver's stall for the next cycle.
  always @(posedge clk) begin
    scatter_beat_t want;
    if (!rst) begin
      if (scatter_valid && !scatter_stall) begin
        if (expected_scatter.size() == 0) begin
          $error("scatter beat with no ray outstanding");
          failed = 1'b1;
        end else begin
          want = expected_scatter.pop_front();
          if (scatter.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, scatter.out_x);
            failed = 1'b1;
          end
          if (scatter.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, scatter.out_y);
            failed = 1'b1;
          end
          if (scatter.out_z !== want.out_z) begin
            $error("out_z: expected %0d, got %0d", want.out_z, scatter.out_z);
            failed = 1'b1;
          end
          if (scatter.was_reflected !== want.was_reflected) begin
            $error("was_reflected: expected %0d, got %0d", want.was_reflected,
                   scatter.was_reflected);
            failed = 1'b1;
          end
          if (scatter.reflectance !== want.reflectance) begin
            $error("reflectance: expected %0d, got %0d", want.reflectance,
                   scatter.reflectance);
            failed = 1'b1;
          end
        end
      end
      if (hold_off_go && !hold_off_done) begin
        scatter_stall <= 1'b1;
      end else begin
        scatter_stall <= $urandom_range(99) < receiver_idle_pct;
      end
    end
  end

  // A ray with random content; mostly unit length directions, sometimes raw noise.
  function automatic ray_beat_t random_ray();
    ray_beat_t r;
    real ux;
    real uy;
    real uz;
    real len;
    r.random_fraction = 16'($urandom);
    if ($urandom_range(9) == 0) begin
      r.dir_x = 16'($urandom);
      r.dir_y = 16'($urandom);
      r.dir_z = 16'($urandom);
    end else begin
      ux = $urandom_range(20000) - 10000.0;
      uy = $urandom_range(20000) - 10000.0;
      uz = $urandom_range(20000) - 10000.0;
      len = $sqrt(ux * ux + uy * uy + uz * uz) + 1.0;
      r.dir_x = 16'($rtoi(ux / len * ONE));
      r.dir_y = 16'($rtoi(uy / len * ONE));
      r.dir_z = 16'($rtoi(uz / len * ONE));
    end
    return r;
  endfunction

  task automatic push_ray(input int x, input int y, input int z, input int rnd);
    ray_beat_t r;
    r.dir_x = 16'(x);
    r.dir_y = 16'(y);
    r.dir_z = 16'(z);
    r.random_fraction = 16'(rnd);
    pending_rays.push_back(r);
  endtask

  // Waits until every ray is through, then lets the pipeline drain fully.
  task automatic drain();
    while (pending_rays.size() != 0 || ray_valid || expected_scatter.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Writes the index while the block is empty; the model follows at the same edge.
  task automatic write_index(input logic [15:0] value);
    refraction_index_we <= 1'b1;
    refraction_index <= value;
    @(posedge clk);
    index_model = value;
    refraction_index_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] ior_plan[6];
    ior_plan = '{16'd24576, 16'd16384, 16'd0, 16'd65535, 16'd16385, 16'd40000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats under the reset index: extremes, grazing, unnormalised and total
    // internal reflection from inside the medium.
    push_ray(0, ONE, 0, 0);
    push_ray(0, ONE, 0, 65535);
    push_ray(0, -ONE, 0, 65535);
    push_ray(ONE, 0, 0, 65535);
    push_ray(-ONE, 0, -ONE, 0);
    push_ray(ONE, 0, ONE, 65535);
    push_ray(-ONE, -ONE, -ONE, 65535);
    push_ray(32767, 32767, 32767, 65535);
    push_ray(-32768, -32768, -32768, 0);
    push_ray(-32768, -32768, -32768, 65535);
    push_ray(15000, -3000, 5000, 65535);
    push_ray(15000, 3000, -5000, 65535);
    push_ray(11585, 11585, 0, 65535);
    push_ray(-11585, -11585, 0, 65535);
    push_ray(0, 1, 16383, 32768);
    push_ray(0, -1, -16383, 32768);
    drain();

    // Back-pressure: the receiver holds off long enough for the pipeline to fill.
    sender_idle_pct = 0;
    hold_off_go = 1'b1;
    for (int i = 0; i < 2 * LATENCY; i++) pending_rays.push_back(random_ray());
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_index(ior_plan[phase]);
      case (phase % 3)
        0: begin sender_idle_pct = 32; receiver_idle_pct = 59; end
        1: begin sender_idle_pct = 59; receiver_idle_pct = 32; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      for (int i = 0; i < 250; i++) pending_rays.push_back(random_ray());
      if (phase == 5) begin
        push_ray(0, -ONE, 0, 65535);
        push_ray(ONE, 0, -ONE, 0);
      end
      drain();
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
sv/dsd_pkg.sv
sv/dielectric_scatter_direction.sv
test/tb_dielectric_scatter_direction.sv
